// ----- rtl/sccc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccc_pkg
// Shared types and codes for the sector cache clock controller.
// ----------------------------------------------------------------------------
package sccc_pkg;

  localparam int CMD_W    = 2;
  localparam int SECTOR_W = 32;
  localparam int ENTRY_W  = 6;

  // request command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [SECTOR_W-1:0] sector;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [ENTRY_W-1:0]  entry;
    logic                fill_needed;
    logic                writeback_valid;
    logic [SECTOR_W-1:0] writeback_sector;
    logic                last;
  } out_item_t;

  // classified request passed from front to back
  typedef struct packed {
    op_t                 op;
    logic [SECTOR_W-1:0] sector;
  } req_t;

endpackage

// ----- rtl/sccc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sccc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sccc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccc_queue
// Two-entry request queue between the front and back ends.
// ----------------------------------------------------------------------------
module sccc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sccc_pkg::req_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output sccc_pkg::req_t pop_data
);

  sccc_pkg::req_t q_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/sccc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccc_front
// Request intake: takes input transfers, decodes the command and queues
// read, write and flush requests. Unused command codes are taken and dropped.
// ----------------------------------------------------------------------------
module sccc_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  sccc_pkg::in_item_t in_data,
  output logic               q_push,
  output sccc_pkg::req_t     q_data,
  input  logic               q_full
);

  logic take;
  logic known;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  always_comb begin
    known         = 1'b1;
    q_data.op     = sccc_pkg::OP_READ;
    q_data.sector = in_data.sector;
    unique case (in_data.command)
      sccc_pkg::CMD_READ:   q_data.op = sccc_pkg::OP_READ;
      sccc_pkg::CMD_WRITE:  q_data.op = sccc_pkg::OP_WRITE;
      sccc_pkg::CMD_FLUSH:  q_data.op = sccc_pkg::OP_FLUSH;
      sccc_pkg::CMD_UNUSED: known     = 1'b0;
      default:              known     = 1'b0;
    endcase
  end

  assign q_push = take && known;

endmodule

// ----- rtl/sccc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccc_back
// Request execution: tag scan, clock victim search, tag update and flush
// walk, with the result register toward the output channel.
// ----------------------------------------------------------------------------
module sccc_back #(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sccc_pkg::req_t      q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output sccc_pkg::out_item_t out_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = sccc_pkg::SECTOR_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_CLK,
    S_WBD,
    S_UPD,
    S_OUT,
    S_FLUSH,
    S_FRD,
    S_FEND
  } state_t;

  state_t              state_r,     state_nxt;
  sccc_pkg::op_t       op_r,        op_nxt;
  logic [SW-1:0]       sec_r,       sec_nxt;
  logic [ENTRIES-1:0]  valid_r,     valid_nxt;
  logic [ENTRIES-1:0]  dirty_r,     dirty_nxt;
  logic [ENTRIES-1:0]  visited_r,   visited_nxt;
  logic [CW-1:0]       idx_r,       idx_nxt;
  logic [IW-1:0]       cmp_r,       cmp_nxt;
  logic                pend_r,      pend_nxt;
  logic                inv_found_r, inv_found_nxt;
  logic [IW-1:0]       inv_r,       inv_nxt;
  logic [IW-1:0]       vic_r,       vic_nxt;
  logic                wbv_r,       wbv_nxt;
  logic [SW-1:0]       wbs_r,       wbs_nxt;
  logic                have_hold_r, have_hold_nxt;
  sccc_pkg::out_item_t hold_r,      hold_nxt;
  sccc_pkg::out_item_t res_r,       res_nxt;
  logic                out_valid_r, out_valid_nxt;
  sccc_pkg::out_item_t out_data_r,  out_data_nxt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;

  logic          out_free;
  logic [IW-1:0] idx_i;
  logic          is_write;
  logic          scan_more;
  sccc_pkg::out_item_t fl_item;

  sccc_ram #(
    .WIDTH (SW),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign idx_i     = idx_r[IW-1:0];
  assign is_write  = (op_r == sccc_pkg::OP_WRITE);
  assign scan_more = (idx_r < CW'(ENTRIES));

  always_comb begin
    fl_item                  = '0;
    fl_item.entry            = sccc_pkg::ENTRY_W'(idx_i);
    fl_item.writeback_valid  = 1'b1;
    fl_item.writeback_sector = ram_rdata;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    sec_nxt       = sec_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    visited_nxt   = visited_r;
    idx_nxt       = idx_r;
    cmp_nxt       = cmp_r;
    pend_nxt      = pend_r;
    inv_found_nxt = inv_found_r;
    inv_nxt       = inv_r;
    vic_nxt       = vic_r;
    wbv_nxt       = wbv_r;
    wbs_nxt       = wbs_r;
    have_hold_nxt = have_hold_r;
    hold_nxt      = hold_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = vic_r;
    ram_wdata     = sec_r;
    ram_raddr     = idx_i;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          op_nxt        = q_data.op;
          sec_nxt       = q_data.sector;
          idx_nxt       = '0;
          pend_nxt      = 1'b0;
          inv_found_nxt = 1'b0;
          have_hold_nxt = 1'b0;
          state_nxt     = (q_data.op == sccc_pkg::OP_FLUSH) ? S_FLUSH : S_LOOK;
        end
      end

      // one tag read issued per cycle; each compare works on registered read data
      S_LOOK: begin
        if (pend_r && valid_r[cmp_r] && (ram_rdata == sec_r)) begin
          visited_nxt[cmp_r] = 1'b1;
          if (is_write) begin
            dirty_nxt[cmp_r] = 1'b1;
          end
          res_nxt       = '0;
          res_nxt.hit   = 1'b1;
          res_nxt.entry = sccc_pkg::ENTRY_W'(cmp_r);
          res_nxt.last  = 1'b1;
          state_nxt     = S_OUT;
        end else if (scan_more) begin
          ram_raddr = idx_i;
          cmp_nxt   = idx_i;
          pend_nxt  = 1'b1;
          idx_nxt   = idx_r + CW'(1);
          if (!valid_r[idx_i] && !inv_found_r) begin
            inv_found_nxt = 1'b1;
            inv_nxt       = idx_i;
          end
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            wbv_nxt = 1'b0;
            wbs_nxt = '0;
            if (inv_found_r) begin
              vic_nxt   = inv_r;
              state_nxt = S_UPD;
            end else begin
              vic_nxt   = '0;
              state_nxt = S_CLK;
            end
          end
        end
      end

      // second-chance walk from entry 0
      S_CLK: begin
        ram_raddr = vic_r;
        if (!visited_r[vic_r]) begin
          state_nxt = dirty_r[vic_r] ? S_WBD : S_UPD;
        end else begin
          visited_nxt[vic_r] = 1'b0;
          vic_nxt = (vic_r == IW'(ENTRIES - 1)) ? '0 : vic_r + IW'(1);
        end
      end

      S_WBD: begin
        ram_raddr          = vic_r;
        wbv_nxt            = 1'b1;
        wbs_nxt            = ram_rdata;
        dirty_nxt[vic_r]   = 1'b0;
        state_nxt          = S_UPD;
      end

      S_UPD: begin
        ram_we               = 1'b1;
        ram_waddr            = vic_r;
        ram_wdata            = sec_r;
        valid_nxt[vic_r]     = 1'b1;
        visited_nxt[vic_r]   = 1'b1;
        dirty_nxt[vic_r]     = is_write;
        res_nxt.hit              = 1'b0;
        res_nxt.entry            = sccc_pkg::ENTRY_W'(vic_r);
        res_nxt.fill_needed      = !is_write;
        res_nxt.writeback_valid  = wbv_r;
        res_nxt.writeback_sector = wbs_r;
        res_nxt.last             = 1'b1;
        state_nxt                = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      S_FLUSH: begin
        ram_raddr = idx_i;
        if (!scan_more) begin
          state_nxt = S_FEND;
        end else if (valid_r[idx_i] && dirty_r[idx_i]) begin
          state_nxt = S_FRD;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      // the held result goes out only once a later one is known to exist
      S_FRD: begin
        ram_raddr = idx_i;
        if (!have_hold_r || out_free) begin
          if (have_hold_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = hold_r;
          end
          hold_nxt         = fl_item;
          have_hold_nxt    = 1'b1;
          dirty_nxt[idx_i] = 1'b0;
          idx_nxt          = idx_r + CW'(1);
          state_nxt        = S_FLUSH;
        end
      end

      S_FEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (have_hold_r) begin
            out_data_nxt      = hold_r;
            out_data_nxt.last = 1'b1;
          end else begin
            out_data_nxt      = '0;
            out_data_nxt.last = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      dirty_r     <= '0;
      visited_r   <= '0;
      pend_r      <= 1'b0;
      have_hold_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      visited_r   <= visited_nxt;
      pend_r      <= pend_nxt;
      have_hold_r <= have_hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    sec_r       <= sec_nxt;
    idx_r       <= idx_nxt;
    cmp_r       <= cmp_nxt;
    inv_found_r <= inv_found_nxt;
    inv_r       <= inv_nxt;
    vic_r       <= vic_nxt;
    wbv_r       <= wbv_nxt;
    wbs_r       <= wbs_nxt;
    hold_r      <= hold_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/sector_cache_clock_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_cache_clock_controller_unit
// Tag and replacement controller for a fully associative write-back sector
// cache with second-chance (clock) replacement.
// ----------------------------------------------------------------------------
// A request is decoded at the input and parked in a two-entry queue; the
// back end handles one request at a time out of a tag RAM with one read
// port, one entry per cycle in the tag scan and clock walk. A read or
// write hit ends the tag scan at the matching entry; a miss scans all
// ENTRIES tags, and when every entry is valid a clock walk follows, plus
// a fetch of a dirty victim's tag. A flush walks all entries and reads
// the tag of each dirty one. Unused command code 3 is taken and produces
// nothing. Tags need no clearing pass after reset: valid bits live in flops.
// ----------------------------------------------------------------------------
module sector_cache_clock_controller_unit #(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sccc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sccc_pkg::out_item_t out_data
);

  logic           q_push;
  sccc_pkg::req_t q_push_data;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  sccc_pkg::req_t q_pop_data;

  sccc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_push_data),
    .q_full   (q_full)
  );

  sccc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_pop_data)
  );

  sccc_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/sccc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sccc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input sccc_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |->
      !out_data.fill_needed && !out_data.writeback_valid && out_data.last)
    else $error("hit with fill or writeback");

  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.writeback_valid |-> out_data.writeback_sector == '0)
    else $error("writeback sector without writeback");

  a_fill_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fill_needed |-> out_data.last && !out_data.hit)
    else $error("fill on non-final or hit result");

endmodule

bind sector_cache_clock_controller_unit sccc_checker u_sccc_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sector cache clock controller. A tracker
// object mirrors the valid, dirty, visited and tag state of every entry. It
// predicts the hit, fill, eviction and writeback outcome of each accepted
// request and matches every result transfer against those predictions in
// order. Directed requests come first, then random read/write/flush traffic
// that fills the cache and forces clock evictions. The input idles and the
// output stalls at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_ENTRIES = 64;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 2 * NUM_ENTRIES + 20;

  class cache_tag_tracker;
    bit                          live    [NUM_ENTRIES];
    bit                          dirty   [NUM_ENTRIES];
    bit                          visited [NUM_ENTRIES];
    bit [sccc_pkg::SECTOR_W-1:0] tag     [NUM_ENTRIES];
    sccc_pkg::out_item_t         pending_outcomes[$];
    int checked, failures;
    int hits, misses, evictions, writebacks, flushes, ignored;

    function int pending_count();
      return pending_outcomes.size();
    endfunction

    function string describe(sccc_pkg::out_item_t r);
      return $sformatf("hit=%0d entry=%0d fill=%0d wb=%0d wb_sector=%h last=%0d",
                       r.hit, r.entry, r.fill_needed, r.writeback_valid,
                       r.writeback_sector, r.last);
    endfunction

    function void note_request(sccc_pkg::in_item_t req);
      sccc_pkg::out_item_t r;
      int                  idx, i;
      bit                  have;
      if (req.command == sccc_pkg::CMD_UNUSED) begin
        ignored++;
        return;
      end
      if (req.command == sccc_pkg::CMD_FLUSH) begin
        // hold each writeback back one step so the final one gets last set
        flushes++;
        have = 0;
        r = '0;
        for (i = 0; i < NUM_ENTRIES; i++) begin
          if (live[i] && dirty[i]) begin
            if (have) pending_outcomes.push_back(r);
            r = '0;
            r.entry = i[sccc_pkg::ENTRY_W-1:0];
            r.writeback_valid = 1'b1;
            r.writeback_sector = tag[i];
            dirty[i] = 1'b0;
            have = 1;
          end
        end
        r.last = 1'b1;
        pending_outcomes.push_back(r);
        return;
      end
      r = '0;
      r.last = 1'b1;
      idx = -1;
      for (i = 0; i < NUM_ENTRIES; i++)
        if (idx < 0 && live[i] && tag[i] == req.sector) idx = i;
      if (idx >= 0) begin
        hits++;
        r.hit = 1'b1;
        visited[idx] = 1'b1;
        if (req.command == sccc_pkg::CMD_WRITE) dirty[idx] = 1'b1;
      end else begin
        misses++;
        for (i = 0; i < NUM_ENTRIES; i++)
          if (idx < 0 && !live[i]) idx = i;
        if (idx < 0) begin
          // second chance walk, always from entry 0
          evictions++;
          idx = 0;
          while (visited[idx]) begin
            visited[idx] = 1'b0;
            idx = (idx + 1) % NUM_ENTRIES;
          end
          if (dirty[idx]) begin
            writebacks++;
            r.writeback_valid = 1'b1;
            r.writeback_sector = tag[idx];
            dirty[idx] = 1'b0;
          end
        end
        live[idx] = 1'b1;
        tag[idx] = req.sector;
        visited[idx] = 1'b1;
        if (req.command == sccc_pkg::CMD_WRITE) dirty[idx] = 1'b1;
        r.fill_needed = (req.command == sccc_pkg::CMD_READ);
      end
      r.entry = idx[sccc_pkg::ENTRY_W-1:0];
      pending_outcomes.push_back(r);
    endfunction

    function void check_result(sccc_pkg::out_item_t got);
      sccc_pkg::out_item_t want;
      checked++;
      if (pending_outcomes.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result %0d arrived unpredicted: %s", checked, describe(got));
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.hit !== want.hit || got.entry !== want.entry ||
          got.fill_needed !== want.fill_needed ||
          got.writeback_valid !== want.writeback_valid ||
          got.writeback_sector !== want.writeback_sector || got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("result %0d mismatch\n  expected %s\n  actual   %s",
                   checked, describe(want), describe(got));
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  sccc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  sccc_pkg::out_item_t out_data;

  cache_tag_tracker              board;
  logic [sccc_pkg::SECTOR_W-1:0] seen[$];
  int  sent_count;
  bit  send_burst;
  int  idle_cycles;

  sector_cache_clock_controller_unit #(.ENTRIES(NUM_ENTRIES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_req(input logic [sccc_pkg::CMD_W-1:0]    cmd,
                          input logic [sccc_pkg::SECTOR_W-1:0] sec);
    sccc_pkg::in_item_t req;
    int                 gap;
    req.command = cmd;
    req.sector = sec;
    if (sent_count % 16 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(req);
    sent_count++;
    if (cmd == sccc_pkg::CMD_READ || cmd == sccc_pkg::CMD_WRITE) begin
      seen.push_back(sec);
      if (seen.size() > 96) void'(seen.pop_front());
    end
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles, giving up", IDLE_LIMIT);
      $display("[sector_cache_clock_controller_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int gap, taken;
    bit burst, held_off;
    taken = 0;
    burst = 0;
    held_off = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (taken % 16 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 12);
      // one long hold-off so the request queue backs up
      if (!held_off && board.checked >= 40) begin
        gap += HOLD_CYCLES;
        held_off = 1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result(out_data);
      taken++;
    end
  end

  initial begin : stimulus
    int n, pick;
    logic [sccc_pkg::CMD_W-1:0] cmd_rw;
    board = new();
    sent_count = 0;
    send_burst = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: hits, misses, extremes, flush with and without dirty entries
    send_req(sccc_pkg::CMD_READ,   32'h0000_0000);
    send_req(sccc_pkg::CMD_READ,   32'h0000_0000);
    send_req(sccc_pkg::CMD_WRITE,  32'hFFFF_FFFF);
    send_req(sccc_pkg::CMD_WRITE,  32'hFFFF_FFFF);
    send_req(sccc_pkg::CMD_FLUSH,  32'h0000_0000);
    send_req(sccc_pkg::CMD_FLUSH,  32'hFFFF_FFFF);
    send_req(sccc_pkg::CMD_UNUSED, 32'hA5A5_A5A5);
    send_req(sccc_pkg::CMD_WRITE,  32'h5A5A_5A5A);
    send_req(sccc_pkg::CMD_READ,   32'h5A5A_5A5A);
    send_req(sccc_pkg::CMD_WRITE,  32'h0000_0000);
    send_req(sccc_pkg::CMD_UNUSED, 32'h0000_0000);
    send_req(sccc_pkg::CMD_FLUSH,  32'h1234_5678);
    send_req(sccc_pkg::CMD_READ,   32'h8000_0000);
    send_req(sccc_pkg::CMD_WRITE,  32'h7FFF_FFFF);
    send_req(sccc_pkg::CMD_READ,   32'h7FFF_FFFF);
    wait_for_drain();

    // random: enough fresh sectors to fill the cache and keep evicting
    n = 0;
    while ((n < 94 || board.evictions < 4) && n < 110) begin
      if (n == 60) wait_for_drain();
      pick = $urandom_range(0, 99);
      cmd_rw = $urandom_range(0, 1) ? sccc_pkg::CMD_WRITE : sccc_pkg::CMD_READ;
      if (pick < 75 || seen.size() == 0) begin
        send_req(cmd_rw, $urandom());
      end else if (pick < 91) begin
        send_req(cmd_rw, seen[$urandom_range(0, seen.size() - 1)]);
      end else if (pick < 97) begin
        send_req(sccc_pkg::CMD_FLUSH, $urandom());
      end else begin
        send_req(sccc_pkg::CMD_UNUSED, $urandom());
        n--;
      end
      n++;
    end
    send_req(sccc_pkg::CMD_FLUSH, $urandom());

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests (%0d ignored), %0d results checked, %0d mismatches",
             sent_count, board.ignored, board.checked, board.failures);
    $display("%0d hits, %0d misses, %0d clock evictions, %0d dirty victims, %0d flushes",
             board.hits, board.misses, board.evictions, board.writebacks, board.flushes);
    if (board.failures == 0 && board.pending_count() == 0) begin
      $display("[sector_cache_clock_controller_unit] OK");
    end else begin
      $display("[sector_cache_clock_controller_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sccc_pkg.sv
rtl/sccc_ram.sv
rtl/sccc_queue.sv
rtl/sccc_front.sv
rtl/sccc_back.sv
rtl/sector_cache_clock_controller_unit.sv
rtl/sccc_checker.sv
bench/testbench.sv
